FILE: rtl/cbenc_pkg.sv
`default_nettype none

package cbenc_pkg;

    localparam int QUIET_ZONE_LEN_DEF = 10;
    localparam int TABLE_SIZE         = 22;
    localparam int PATTERN_LEN        = 7;

    // wide flags, first element in bit 6
    localparam logic [PATTERN_LEN-1:0] MASK_START = 7'h29;
    localparam logic [PATTERN_LEN-1:0] MASK_STOP  = 7'h0E;

    localparam logic [7:0] CB_CODE [TABLE_SIZE] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h41, 8'h54, 8'h42, 8'h4E, 8'h43, 8'h2A, 8'h44, 8'h45,
        8'h2E, 8'h2F, 8'h3A, 8'h2B
    };

    localparam logic [PATTERN_LEN-1:0] CB_MASK [TABLE_SIZE] = '{
        7'h03, 7'h06, 7'h09, 7'h60, 7'h12, 7'h42, 7'h21, 7'h24, 7'h30, 7'h48,
        7'h1A, 7'h1A, 7'h29, 7'h29, 7'h0B, 7'h0B, 7'h0E, 7'h0E,
        7'h54, 7'h51, 7'h45, 7'h15
    };

    typedef struct packed {
        logic [7:0] symbol_code;
        logic       first_symbol;
        logic       last_symbol;
    } sym_in_t;

    typedef struct packed {
        logic is_space;
        logic is_wide;
        logic last_element;
        logic bad_symbol;
    } elem_out_t;

    typedef struct packed {
        logic                   hit;
        logic [PATTERN_LEN-1:0] mask;
    } lookup_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_BAD   = 7'b0000010,
        S_QPRE  = 7'b0000100,
        S_START = 7'b0001000,
        S_CHAR  = 7'b0010000,
        S_STOP  = 7'b0100000,
        S_QPOST = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        EL_QUIET = 3'd0,
        EL_BAD   = 3'd1,
        EL_START = 3'd2,
        EL_CHAR  = 3'd3,
        EL_STOP  = 3'd4
    } el_sel_t;

    typedef struct packed {
        logic    load;
        logic    emit;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    last_el;
        el_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic out_ready;
        logic new_bad;
        logic new_first;
        logic held_last;
        logic pat_end;
        logic gap;
        logic qz_end;
    } dp_sts_t;

    function automatic lookup_t cb_lookup(input logic [7:0] code);
        lookup_t res;
        res.hit  = 1'b0;
        res.mask = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (CB_CODE[i] == code)
            begin
                res.hit  = 1'b1;
                res.mask = CB_MASK[i];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cbenc_dp.sv
`default_nettype none

module cbenc_dp #(
    parameter int QUIET_ZONE_LEN = cbenc_pkg::QUIET_ZONE_LEN_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  cbenc_pkg::sym_in_t   in_data,
    input  cbenc_pkg::dp_cmd_t   cmd,
    output cbenc_pkg::dp_sts_t   sts,
    output logic                 out_valid,
    input  wire                  out_stall,
    output cbenc_pkg::elem_out_t out_data
);
    import cbenc_pkg::*;

    localparam int CNT_W = (QUIET_ZONE_LEN > 8) ? $clog2(QUIET_ZONE_LEN) : 3;

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [PATTERN_LEN-1:0] mask_reg, mask_next;
    logic                   last_reg, last_next;
    logic                   out_valid_reg, out_valid_next;
    elem_out_t              out_data_reg, out_data_next;
    lookup_t                lkp;
    logic [PATTERN_LEN-1:0] pat_mask;
    logic [2:0]             pos;
    elem_out_t              elem;

    assign lkp = cb_lookup(in_data.symbol_code);
    assign pos = cnt_reg[2:0];

    always_comb
    begin
        case (cmd.sel)
            EL_START: pat_mask = MASK_START;
            EL_STOP:  pat_mask = MASK_STOP;
            default:  pat_mask = mask_reg;
        endcase
    end

    always_comb
    begin
        elem.is_space     = 1'b1;
        elem.is_wide      = 1'b0;
        elem.last_element = cmd.last_el;
        elem.bad_symbol   = 1'b0;
        case (cmd.sel)
            EL_QUIET:
            begin
                elem.is_space = 1'b1;
            end
            EL_BAD:
            begin
                elem.is_space   = 1'b0;
                elem.bad_symbol = 1'b1;
            end
            EL_START, EL_CHAR, EL_STOP:
            begin
                // position seven is the narrow gap after a character
                if (pos == 3'd7)
                begin
                    elem.is_space = 1'b1;
                end
                else
                begin
                    elem.is_space = pos[0];
                    elem.is_wide  = pat_mask[3'd6 - pos];
                end
            end
            default:
            begin
                elem.is_space = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        mask_next      = mask_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.cnt_clr)
            cnt_next = '0;
        else if (cmd.cnt_inc)
            cnt_next = cnt_reg + 1'b1;
        if (cmd.load)
        begin
            mask_next = lkp.mask;
            last_next = in_data.last_symbol;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = elem;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg     <= mask_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        sts.out_ready = !out_valid_reg || !out_stall;
        sts.new_bad   = !lkp.hit;
        sts.new_first = in_data.first_symbol;
        sts.held_last = last_reg;
        sts.pat_end   = (cnt_reg == CNT_W'(6));
        sts.gap       = (cnt_reg == CNT_W'(7));
        sts.qz_end    = (cnt_reg == CNT_W'(QUIET_ZONE_LEN - 1));
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/cbenc_ctrl.sv
`default_nettype none

module cbenc_ctrl #(
    parameter int QUIET_ZONE_LEN = cbenc_pkg::QUIET_ZONE_LEN_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  cbenc_pkg::dp_sts_t sts,
    output cbenc_pkg::dp_cmd_t cmd
);
    import cbenc_pkg::*;

    localparam bit HAS_QZ = (QUIET_ZONE_LEN > 0);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.emit    = 1'b0;
        cmd.cnt_clr = 1'b0;
        cmd.cnt_inc = 1'b0;
        cmd.last_el = 1'b0;
        cmd.sel     = EL_QUIET;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    if (sts.new_bad)
                        state_next = S_BAD;
                    else if (sts.new_first)
                        state_next = HAS_QZ ? S_QPRE : S_START;
                    else
                        state_next = S_CHAR;
                end
            end
            S_BAD:
            begin
                cmd.sel     = EL_BAD;
                cmd.last_el = 1'b1;
                if (sts.out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_QPRE:
            begin
                cmd.sel = EL_QUIET;
                if (sts.out_ready)
                begin
                    cmd.emit = 1'b1;
                    if (sts.qz_end)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_START;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            S_START:
            begin
                cmd.sel = EL_START;
                if (sts.out_ready)
                begin
                    cmd.emit = 1'b1;
                    if (sts.gap)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_CHAR;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            S_CHAR:
            begin
                cmd.sel     = EL_CHAR;
                cmd.last_el = sts.gap && !sts.held_last;
                if (sts.out_ready)
                begin
                    cmd.emit = 1'b1;
                    if (sts.gap)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = sts.held_last ? S_STOP : S_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            S_STOP:
            begin
                // stop symbol has no trailing gap
                cmd.sel     = EL_STOP;
                cmd.last_el = sts.pat_end && !HAS_QZ;
                if (sts.out_ready)
                begin
                    cmd.emit = 1'b1;
                    if (sts.pat_end)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = HAS_QZ ? S_QPOST : S_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            S_QPOST:
            begin
                cmd.sel     = EL_QUIET;
                cmd.last_el = sts.qz_end;
                if (sts.out_ready)
                begin
                    cmd.emit = 1'b1;
                    if (sts.qz_end)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/codabar_symbol_encoder.sv
// Codabar symbol encoder: one ASCII character in, a run of bar/space elements out.
// Input channel in_valid/in_stall/in_data carries the character with its
// first_symbol and last_symbol flags. Output channel out_valid/out_stall/out_data
// carries one element per transaction; last_element marks the final element of
// each input transaction, bad_symbol flags a character outside the table.
// After the input transaction the sequencer leaves idle, then registers each element.
// Throughput: one element per cycle from the output register while not stalled.
// A plain character gives 7 pattern elements and a narrow gap.
// first_symbol adds a quiet zone of QUIET_ZONE_LEN elements, start B and a gap;
// last_symbol adds stop E (7 elements, no gap) and a quiet zone. An unknown
// character gives a single element.
// The sequencer accepts one transaction at a time; in_stall is high until the
// final element has been loaded into the output register, so the next character
// may enter while that element is still waiting at the output.
// A stall on a valid output holds the element and freezes the sequencer outside idle.
// Reset clears the sequencer to idle and empties the output register.
`default_nettype none

module codabar_symbol_encoder #(
    parameter int QUIET_ZONE_LEN = cbenc_pkg::QUIET_ZONE_LEN_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  cbenc_pkg::sym_in_t   in_data,
    output logic                 out_valid,
    input  wire                  out_stall,
    output cbenc_pkg::elem_out_t out_data
);
    import cbenc_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    cbenc_ctrl #(
        .QUIET_ZONE_LEN(QUIET_ZONE_LEN)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .cmd     (cmd)
    );

    cbenc_dp #(
        .QUIET_ZONE_LEN(QUIET_ZONE_LEN)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/cbenc_chk.sv
`default_nettype none

module cbenc_chk (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  in_valid,
    input wire                  in_stall,
    input wire                  out_valid,
    input wire                  out_stall,
    input cbenc_pkg::elem_out_t out_data
);
    import cbenc_pkg::*;

    // an error element always closes its transaction
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bad_symbol |-> out_data.last_element)
        else $error("bad_symbol without last_element");

    // an error element is reported as a narrow bar
    a_bad_is_bar: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bad_symbol |-> !out_data.is_space && !out_data.is_wide)
        else $error("bad_symbol element is not a narrow bar");

    // every accepted character causes at least one element, so intake closes
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output changed");

endmodule

bind codabar_symbol_encoder cbenc_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

`default_nettype wire

FILE: tb/sv/codabar_symbol_encoder_tb.sv
`timescale 1ns / 1ps

module codabar_symbol_encoder_tb;
    import cbenc_pkg::*;

    localparam int QUIET_LEN    = QUIET_ZONE_LEN_DEF;
    localparam int SYMBOL_COUNT = 330;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 60;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_SHOWN    = 40;
    localparam int NUM_SYMBOLS  = 22;
    localparam int BAR_COUNT    = 7;

    localparam logic [6:0] START_WIDE = 7'h29;
    localparam logic [6:0] STOP_WIDE  = 7'h0E;

    // character set: digits, A-D with aliases T N * E, then . / : +
    localparam logic [7:0] SYM_CODE [NUM_SYMBOLS] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h41, 8'h54, 8'h42, 8'h4E, 8'h43, 8'h2A, 8'h44, 8'h45,
        8'h2E, 8'h2F, 8'h3A, 8'h2B
    };

    // wide flags, first element in bit 6
    localparam logic [6:0] SYM_WIDE [NUM_SYMBOLS] = '{
        7'h03, 7'h06, 7'h09, 7'h60, 7'h12, 7'h42, 7'h21, 7'h24, 7'h30, 7'h48,
        7'h1A, 7'h1A, 7'h29, 7'h29, 7'h0B, 7'h0B, 7'h0E, 7'h0E,
        7'h54, 7'h51, 7'h45, 7'h15
    };

    typedef struct {
        sym_in_t sym;
        int      gap_before;
        bit      drain;
    } symbol_req_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    sym_in_t   in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    elem_out_t out_data;

    symbol_req_t symbol_queue [$];
    elem_out_t   pending_elems [$];

    bit  in_taken = 1'b0;
    bit  out_taken;
    int  symbols_taken = 0;
    int  elems_checked = 0;
    int  idle_cycles = 0;
    int  error_count = 0;
    int  rx_cycle = 0;
    int  stall_left = 0;
    int  stall_pick;
    bit  stall_now;
    bit  hold_done = 1'b0;
    elem_out_t want;

    codabar_symbol_encoder #(
        .QUIET_ZONE_LEN(QUIET_LEN)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always #4 clk = ~clk;

    task automatic report(input string msg);
        if (error_count < MAX_SHOWN)
            $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic bit find_pattern(input logic [7:0] code, output logic [6:0] wide);
        find_pattern = 1'b0;
        wide = '0;
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            if (SYM_CODE[i] == code)
            begin
                find_pattern = 1'b1;
                wide = SYM_WIDE[i];
            end
        end
    endfunction

    task automatic push_elem(input logic space, input logic wide);
        elem_out_t e;
        e.is_space     = space;
        e.is_wide      = wide;
        e.last_element = 1'b0;
        e.bad_symbol   = 1'b0;
        pending_elems.push_back(e);
    endtask

    task automatic push_quiet();
        for (int i = 0; i < QUIET_LEN; i++)
            push_elem(1'b1, 1'b0);
    endtask

    // bars on even positions, spaces on odd ones
    task automatic push_pattern(input logic [6:0] wide);
        for (int p = 0; p < BAR_COUNT; p++)
            push_elem(p[0], wide[BAR_COUNT - 1 - p]);
    endtask

    task automatic expand_symbol(input sym_in_t sym);
        logic [6:0] wide;
        bit         known;
        int         last_idx;
        known = find_pattern(sym.symbol_code, wide);
        if (!known)
        begin
            // unknown character: one flagged element, flags ignored
            push_elem(1'b0, 1'b0);
            last_idx = pending_elems.size() - 1;
            pending_elems[last_idx].bad_symbol = 1'b1;
        end
        else
        begin
            if (sym.first_symbol)
            begin
                push_quiet();
                push_pattern(START_WIDE);
                push_elem(1'b1, 1'b0);
            end
            push_pattern(wide);
            push_elem(1'b1, 1'b0);
            if (sym.last_symbol)
            begin
                push_pattern(STOP_WIDE);
                push_quiet();
            end
            last_idx = pending_elems.size() - 1;
        end
        pending_elems[last_idx].last_element = 1'b1;
    endtask

    task automatic check_field(input string name, input logic got, input logic exp_bit);
        if (got !== exp_bit)
            report($sformatf("element %0d %s got %b want %b", elems_checked, name, got, exp_bit));
    endtask

    function automatic int pick_gap(input bit bursty);
        int r;
        r = $urandom_range(99);
        if (bursty || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] any_legal();
        return SYM_CODE[$urandom_range(NUM_SYMBOLS - 1)];
    endfunction

    task automatic add_symbol(input logic [7:0] code, input logic first, input logic last,
                              input int gap, input bit drain);
        symbol_req_t req;
        req.sym.symbol_code  = code;
        req.sym.first_symbol = first;
        req.sym.last_symbol  = last;
        req.gap_before       = gap;
        req.drain            = drain;
        symbol_queue.push_back(req);
    endtask

    // sender: offers queued symbols, holds a stalled transaction unchanged
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (symbol_queue.size() == 0)
                in_valid <= 1'b0;
            else if (symbol_queue[0].gap_before > 0)
            begin
                symbol_queue[0].gap_before = symbol_queue[0].gap_before - 1;
                in_valid <= 1'b0;
            end
            else if (symbol_queue[0].drain && pending_elems.size() != 0)
                in_valid <= 1'b0;
            else
            begin
                in_data  <= symbol_queue[0].sym;
                in_valid <= 1'b1;
                void'(symbol_queue.pop_front());
            end
        end
    end

    // receiver: random stalls, quiet stretches, and one long hold-off
    always @(negedge clk)
    begin
        rx_cycle++;
        if (!hold_done && symbols_taken >= HOLD_AT)
        begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            stall_now = 1'b1;
        end
        else if ((rx_cycle % 600) < 150)
            stall_now = 1'b0;
        else
        begin
            stall_pick = $urandom_range(99);
            if (stall_pick < 70)
                stall_now = 1'b0;
            else
            begin
                stall_now  = 1'b1;
                stall_left = (stall_pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 30);
            end
        end
        out_stall <= stall_now;
    end

    // monitor: predicts on input transactions, checks output transactions
    always @(posedge clk)
    begin
        in_taken  = rst_n && in_valid && !in_stall;
        out_taken = rst_n && out_valid && !out_stall;
        if (in_taken)
        begin
            expand_symbol(in_data);
            symbols_taken++;
        end
        if (out_taken)
        begin
            if (pending_elems.size() == 0)
                report($sformatf("unexpected element %b", out_data));
            else
            begin
                want = pending_elems.pop_front();
                check_field("is_space", out_data.is_space, want.is_space);
                check_field("is_wide", out_data.is_wide, want.is_wide);
                check_field("last_element", out_data.last_element, want.last_element);
                check_field("bad_symbol", out_data.bad_symbol, want.bad_symbol);
            end
            elems_checked++;
        end
        idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
    end

    initial
    begin
        int  filled;
        int  msg_len;
        int  kind;
        bit  bursty;
        bit  drain_next;

        // every table entry, first and last flags, codes outside the table
        add_symbol(SYM_CODE[0], 1'b1, 1'b0, 0, 1'b0);
        for (int d = 1; d < NUM_SYMBOLS - 1; d++)
            add_symbol(SYM_CODE[d], 1'b0, 1'b0, pick_gap(1'b0), 1'b0);
        add_symbol(SYM_CODE[NUM_SYMBOLS - 1], 1'b0, 1'b1, 0, 1'b0);
        add_symbol(8'h00, 1'b1, 1'b1, 0, 1'b0);
        add_symbol(8'hFF, 1'b0, 1'b0, 1, 1'b0);
        add_symbol(8'h61, 1'b1, 1'b0, 0, 1'b0);
        add_symbol(8'h35, 1'b1, 1'b1, 0, 1'b0);
        filled = symbol_queue.size();

        drain_next = 1'b1;
        while (filled < SYMBOL_COUNT)
        begin
            kind   = $urandom_range(99);
            bursty = ($urandom_range(99) < 20);
            if (kind < 80)
            begin
                // well-formed message
                msg_len = $urandom_range(1, 8);
                for (int i = 0; i < msg_len; i++)
                    add_symbol(any_legal(), i == 0, i == msg_len - 1, pick_gap(bursty),
                               (i == 0) && (drain_next || $urandom_range(99) < 5));
                filled += msg_len;
                drain_next = 1'b0;
            end
            else if (kind < 90)
            begin
                add_symbol(8'($urandom_range(255)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), pick_gap(bursty), 1'b0);
                filled++;
            end
            else
            begin
                // broken message: random flags, some unknown characters
                msg_len = $urandom_range(1, 6);
                for (int i = 0; i < msg_len; i++)
                    add_symbol(($urandom_range(3) != 0) ? any_legal() : 8'($urandom_range(255)),
                               1'($urandom_range(1)), 1'($urandom_range(1)),
                               pick_gap(bursty), 1'b0);
                filled += msg_len;
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(symbol_queue.size() == 0 && !in_valid && pending_elems.size() == 0)
               && idle_cycles < IDLE_LIMIT)
            @(posedge clk);

        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("codabar_symbol_encoder_tb: errors");
        end
        else
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (pending_elems.size() != 0)
                report($sformatf("%0d elements never arrived", pending_elems.size()));
            if (error_count == 0)
                $display("codabar_symbol_encoder_tb: clean");
            else
                $display("codabar_symbol_encoder_tb: errors");
        end
        $finish;
    end

endmodule
